>>> sv/cmd_pkg.sv
`default_nettype none

package cmd_pkg;

  // Fixed field widths of the resource stream and of a result
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned PIX_W      = 4;
  localparam int unsigned MAX_COLS   = 16;
  localparam int unsigned PIXELS_W   = MAX_COLS * PIX_W;
  localparam int unsigned ROW_OUT_W  = 4;

  // Pixel codes
  localparam logic [PIX_W-1:0] PIX_TRANSPARENT = 4'h3;
  localparam logic [PIX_W-1:0] PIX_WHITE       = 4'hf;
  localparam logic [PIX_W-1:0] PIX_GRAY        = 4'h7;
  localparam logic [PIX_W-1:0] PIX_BLACK       = 4'h0;

  // Legacy hot spot: centre when the low byte of the y word is nonzero
  localparam logic [WORD_W-1:0] HOT_LOW_BYTE = 16'h00ff;
  localparam logic [WORD_W-1:0] HOT_CENTRE   = 16'd8;

  typedef enum logic {
    KIND_HOT = 1'b0,
    KIND_ROW = 1'b1
  } kind_t;

  // Combine one mask bit and one color bit into a pixel code
  function automatic logic [PIX_W-1:0] pix_code(input logic m, input logic c,
                                                input logic legacy);
    logic [PIX_W-1:0] p;
    if (!m) begin
      p = c ? PIX_WHITE : PIX_BLACK;
    end else if (c) begin
      p = legacy ? PIX_WHITE : PIX_GRAY;
    end else begin
      p = PIX_TRANSPARENT;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

>>> sv/cmd_item_if.sv
`default_nettype none

interface cmd_item_if;
  logic                       valid;
  logic                       ready;
  logic [cmd_pkg::WORD_W-1:0] word;
  logic                       start_req;

  modport source (output valid, output word, output start_req, input ready);
  modport sink   (input valid, input word, input start_req, output ready);
endinterface

`default_nettype wire

>>> sv/cmd_result_if.sv
`default_nettype none

interface cmd_result_if;
  logic                          valid;
  logic                          ready;
  cmd_pkg::kind_t                kind;
  logic [cmd_pkg::WORD_W-1:0]    hot_x;
  logic [cmd_pkg::WORD_W-1:0]    hot_y;
  logic [cmd_pkg::ROW_OUT_W-1:0] picture_row;
  logic [cmd_pkg::PIXELS_W-1:0]  pixels;
  logic                          last;

  modport source (output valid, output kind, output hot_x, output hot_y,
                  output picture_row, output pixels, output last, input ready);
  modport sink   (input valid, input kind, input hot_x, input hot_y,
                  input picture_row, input pixels, input last, output ready);
endinterface

`default_nettype wire

>>> sv/cmd_cfg_if.sv
`default_nettype none

interface cmd_cfg_if;
  logic valid;
  logic ready;
  logic legacy_mode;

  modport source (output valid, output legacy_mode, input ready);
  modport sink   (input valid, input legacy_mode, output ready);
endinterface

`default_nettype wire

>>> sv/cmd_row_pack.sv
`default_nettype none

module cmd_row_pack #(
  parameter int unsigned SIZE = 16
) (
  input  logic [SIZE-1:0]              mask,
  input  logic [SIZE-1:0]              color,
  input  logic                         legacy,
  output logic [cmd_pkg::PIXELS_W-1:0] pixels
);
  import cmd_pkg::*;

  // Bit SIZE-1 is column 0; columns past the cursor width stay black
  for (genvar i = 0; i < MAX_COLS; i++) begin : g_col
    if (i < SIZE) begin : g_used
      assign pixels[PIX_W*i +: PIX_W] =
        pix_code(mask[SIZE-1-i], color[SIZE-1-i], legacy);
    end else begin : g_unused
      assign pixels[PIX_W*i +: PIX_W] = PIX_BLACK;
    end
  end

endmodule

`default_nettype wire

>>> sv/cursor_mask_decoder_top.sv
`default_nettype none

// Cursor mask decoder. Takes one word of a cursor resource (hot spot x, hot
// spot y, CURSOR_SIZE mask rows, CURSOR_SIZE color rows) per beat and gives
// one hot spot result on the y word and one row of 4-bit pixels per color
// row, rows flipped vertically. A word is accepted every cycle while the
// result side keeps up. An accepted word's result passes in turn through
// the word register, which reads the mask store, and the result register,
// which holds the combined row. Words that give no result never occupy
// the word stage. start_req restarts the resource at hot spot x. legacy_mode
// (reset 1) may be written only while the block is idle.
module cursor_mask_decoder_top #(
  parameter int unsigned CURSOR_SIZE = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  cmd_item_if.sink    items,
  cmd_result_if.source results,
  cmd_cfg_if.sink     cfg
);
  import cmd_pkg::*;

  localparam int unsigned TOTAL = 2 + 2 * CURSOR_SIZE;
  localparam int unsigned POS_W = $clog2(TOTAL);
  localparam int unsigned IDX_W = (CURSOR_SIZE > 1) ? $clog2(CURSOR_SIZE) : 1;

  // Stream state
  logic                   legacy_mode;
  logic [POS_W-1:0]       pos;
  logic [WORD_W-1:0]      saved_hot_x;
  logic [CURSOR_SIZE-1:0] mask_rows [CURSOR_SIZE];

  // Word stage
  logic                   s1_valid;
  kind_t                  s1_kind;
  logic [WORD_W-1:0]      s1_hot_x;
  logic [WORD_W-1:0]      s1_hot_y;
  logic [ROW_OUT_W-1:0]   s1_row;
  logic [CURSOR_SIZE-1:0] s1_mask;
  logic [CURSOR_SIZE-1:0] s1_color;
  logic                   s1_legacy;
  logic                   s1_last;

  logic                   item_acc;
  logic                   out_free;
  logic [POS_W-1:0]       pos_cur;
  logic [POS_W-1:0]       pos_next;
  logic                   is_hot_x;
  logic                   is_hot_y;
  logic                   is_mask;
  logic                   is_color;
  logic [IDX_W-1:0]       mask_idx;
  logic [IDX_W-1:0]       color_idx;
  logic [WORD_W-1:0]      hot_x_sel;
  logic [WORD_W-1:0]      hot_y_sel;
  logic [PIXELS_W-1:0]    row_pixels;

  // Configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      legacy_mode <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      legacy_mode <= cfg.legacy_mode;
    end
  end

  // Decode the position of the incoming word
  assign out_free    = !results.valid || results.ready;
  assign items.ready = !s1_valid || out_free;
  assign item_acc    = items.valid && items.ready;

  assign pos_cur   = items.start_req ? '0 : pos;
  assign pos_next  = (pos_cur == POS_W'(TOTAL - 1)) ? '0 : pos_cur + POS_W'(1);
  assign is_hot_x  = (pos_cur == '0);
  assign is_hot_y  = (pos_cur == POS_W'(1));
  assign is_mask   = (pos_cur >= POS_W'(2)) && (pos_cur < POS_W'(2 + CURSOR_SIZE));
  assign is_color  = (pos_cur >= POS_W'(2 + CURSOR_SIZE));
  assign mask_idx  = IDX_W'(pos_cur - POS_W'(2));
  assign color_idx = IDX_W'(pos_cur - POS_W'(2 + CURSOR_SIZE));

  // Hot spot: two-choice in legacy mode, as sent otherwise
  always_comb begin
    if (legacy_mode) begin
      hot_x_sel = ((items.word & HOT_LOW_BYTE) != '0) ? HOT_CENTRE : '0;
      hot_y_sel = hot_x_sel;
    end else begin
      hot_x_sel = saved_hot_x;
      hot_y_sel = items.word;
    end
  end

  // Advance the position and capture hot spot x and mask rows
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      saved_hot_x <= '0;
    end else if (item_acc) begin
      pos <= pos_next;
      if (is_hot_x) begin
        saved_hot_x <= items.word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc && is_mask) begin
      mask_rows[mask_idx] <= items.word[CURSOR_SIZE-1:0];
    end
  end

  // Word stage: hold a result-bearing beat until the result register frees
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= item_acc && (is_hot_y || is_color);
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      s1_legacy <= legacy_mode;
      s1_color  <= items.word[CURSOR_SIZE-1:0];
      if (is_color) begin
        s1_kind  <= KIND_ROW;
        s1_hot_x <= '0;
        s1_hot_y <= '0;
        s1_row   <= ROW_OUT_W'(CURSOR_SIZE - 1) - ROW_OUT_W'(color_idx);
        s1_last  <= (color_idx == IDX_W'(CURSOR_SIZE - 1));
        s1_mask  <= mask_rows[color_idx];
      end else begin
        s1_kind  <= KIND_HOT;
        s1_hot_x <= hot_x_sel;
        s1_hot_y <= hot_y_sel;
        s1_row   <= '0;
        s1_last  <= 1'b0;
        s1_mask  <= '0;
      end
    end
  end

  // Combine mask and color into pixels
  cmd_row_pack #(
    .SIZE (CURSOR_SIZE)
  ) u_row_pack (
    .mask   (s1_mask),
    .color  (s1_color),
    .legacy (s1_legacy),
    .pixels (row_pixels)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_free) begin
      results.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      results.kind        <= s1_kind;
      results.hot_x       <= s1_hot_x;
      results.hot_y       <= s1_hot_y;
      results.picture_row <= s1_row;
      results.pixels      <= (s1_kind == KIND_ROW) ? row_pixels : '0;
      results.last        <= s1_last;
    end
  end

  // A start word always leaves the position at hot spot y
  a_start_pos: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready && items.start_req) |=> (pos == POS_W'(1)))
    else $error("position not at hot spot y after start word");

  // A stalled word stage holds its beat
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> (s1_valid && $stable(s1_row) && $stable(s1_kind)))
    else $error("word stage lost a beat under stall");

  // The final row of a resource is picture row zero
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.last) |->
      (results.kind == KIND_ROW && results.picture_row == '0))
    else $error("last flag on a result other than picture row zero");

endmodule

`default_nettype wire

>>> test/tb_cursor_mask_decoder_top.sv
`default_nettype none

module tb_cursor_mask_decoder_top;
  import cmd_pkg::*;

  localparam int unsigned ROWS = 16;
  localparam int unsigned FIRST_COLOUR_WORD = 2 + ROWS;
  localparam int unsigned RESOURCE_WORDS = 2 + 2 * ROWS;
  localparam int unsigned RANDOM_WORDS = 1300;
  localparam int unsigned PLAN_LEN = 25;

  // One decoded result, laid out as on the result channel
  typedef struct packed {
    kind_t                 kind;
    logic [WORD_W-1:0]     hot_x;
    logic [WORD_W-1:0]     hot_y;
    logic [ROW_OUT_W-1:0]  picture_row;
    logic [PIXELS_W-1:0]   pixels;
    logic                  last;
  } cursor_result_t;

  typedef enum logic {
    STEP_WORD = 1'b0,
    STEP_CFG  = 1'b1
  } step_t;

  // Directed step: a word beat or a legacy_mode write (value in word bit 0).
  // Where typed is set the hot spot result is given here directly.
  typedef struct packed {
    step_t             op;
    logic [WORD_W-1:0] word;
    logic              start;
    logic              typed;
    logic [WORD_W-1:0] hx;
    logic [WORD_W-1:0] hy;
  } plan_row_t;

  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // after reset: legacy on, position 0 without a start flag
    '{STEP_WORD, 16'hffff, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{STEP_WORD, 16'h0001, 1'b0, 1'b1, 16'h0008, 16'h0008},
    '{STEP_WORD, 16'h0000, 1'b1, 1'b0, 16'h0000, 16'h0000},
    '{STEP_WORD, 16'hff00, 1'b0, 1'b1, 16'h0000, 16'h0000},
    '{STEP_WORD, 16'h8000, 1'b1, 1'b0, 16'h0000, 16'h0000},
    '{STEP_WORD, 16'h0080, 1'b0, 1'b1, 16'h0008, 16'h0008},
    '{STEP_WORD, 16'h0000, 1'b1, 1'b0, 16'h0000, 16'h0000},
    '{STEP_WORD, 16'h00ff, 1'b0, 1'b1, 16'h0008, 16'h0008},
    '{STEP_WORD, 16'hffff, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{STEP_WORD, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    // start flag in the mask rows drops the partial resource
    '{STEP_WORD, 16'haaaa, 1'b1, 1'b0, 16'h0000, 16'h0000},
    '{STEP_WORD, 16'h0100, 1'b0, 1'b1, 16'h0000, 16'h0000},
    '{STEP_CFG,  16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{STEP_WORD, 16'hffff, 1'b1, 1'b0, 16'h0000, 16'h0000},
    '{STEP_WORD, 16'hffff, 1'b0, 1'b1, 16'hffff, 16'hffff},
    '{STEP_WORD, 16'h0000, 1'b1, 1'b0, 16'h0000, 16'h0000},
    '{STEP_WORD, 16'h0000, 1'b0, 1'b1, 16'h0000, 16'h0000},
    '{STEP_WORD, 16'h1234, 1'b1, 1'b0, 16'h0000, 16'h0000},
    '{STEP_WORD, 16'habcd, 1'b0, 1'b1, 16'h1234, 16'habcd},
    // start flag on the y word: taken as x again
    '{STEP_WORD, 16'h7fff, 1'b1, 1'b0, 16'h0000, 16'h0000},
    '{STEP_WORD, 16'h8001, 1'b1, 1'b0, 16'h0000, 16'h0000},
    '{STEP_WORD, 16'h0002, 1'b0, 1'b1, 16'h8001, 16'h0002},
    '{STEP_CFG,  16'h0001, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{STEP_WORD, 16'h5555, 1'b1, 1'b0, 16'h0000, 16'h0000},
    '{STEP_WORD, 16'h0300, 1'b0, 1'b1, 16'h0000, 16'h0000}
  };

  logic clk;
  logic rst;

  cmd_item_if   items_if ();
  cmd_result_if results_if ();
  cmd_cfg_if    cfg_if ();

  cursor_mask_decoder_top dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  // Decoder state as the block should hold it
  logic              legacy_q;
  logic [5:0]        position_q;
  logic [WORD_W-1:0] hot_x_q;
  logic [WORD_W-1:0] mask_store [ROWS];

  cursor_result_t pending_cursor_results [$];
  int unsigned    mismatch_count = 0;
  int unsigned    words_sent = 0;
  int unsigned    burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  // Decode one accepted word and give the result it causes, if any
  task automatic decode_word(input logic [WORD_W-1:0] w, input logic s,
                             output logic produced, output cursor_result_t r);
    logic [3:0]       stream_row;
    logic             m;
    logic             c;
    logic [PIX_W-1:0] p;
    int               col;
    produced = 1'b0;
    r = '0;
    if (s) begin
      position_q = '0;
    end
    if (position_q == 6'd0) begin
      hot_x_q = w;
    end else if (position_q == 6'd1) begin
      produced = 1'b1;
      r.kind = KIND_HOT;
      if (legacy_q) begin
        r.hot_x = ((w & HOT_LOW_BYTE) != '0) ? HOT_CENTRE : '0;
        r.hot_y = r.hot_x;
      end else begin
        r.hot_x = hot_x_q;
        r.hot_y = w;
      end
    end else if (position_q < 6'(FIRST_COLOUR_WORD)) begin
      mask_store[4'(position_q - 6'd2)] = w;
    end else begin
      stream_row = 4'(position_q - 6'(FIRST_COLOUR_WORD));
      produced = 1'b1;
      r.kind = KIND_ROW;
      r.picture_row = 4'(ROWS - 1) - stream_row;
      r.last = (stream_row == 4'(ROWS - 1));
      // bit 15 of the row word is column 0
      for (col = 0; col < ROWS; col++) begin
        m = mask_store[stream_row][ROWS - 1 - col];
        c = w[ROWS - 1 - col];
        if (!m) begin
          p = c ? PIX_WHITE : PIX_BLACK;
        end else if (c) begin
          p = legacy_q ? PIX_WHITE : PIX_GRAY;
        end else begin
          p = PIX_TRANSPARENT;
        end
        r.pixels[PIX_W*col +: PIX_W] = p;
      end
    end
    position_q = (position_q == 6'(RESOURCE_WORDS - 1)) ? 6'd0 : position_q + 6'd1;
  endtask

  // Send one word beat, opening a gap first when the current burst is spent
  task automatic push_word(input logic [WORD_W-1:0] w, input logic s,
                           input logic typed, input cursor_result_t typed_r);
    logic           produced;
    cursor_result_t r;
    if (burst_left == 0) begin
      items_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    items_if.valid     <= 1'b1;
    items_if.word      <= w;
    items_if.start_req <= s;
    do @(posedge clk); while (!items_if.ready);
    burst_left--;
    words_sent++;
    decode_word(w, s, produced, r);
    if (typed) begin
      pending_cursor_results = {pending_cursor_results, typed_r};
    end else if (produced) begin
      pending_cursor_results = {pending_cursor_results, r};
    end
  endtask

  // Write legacy_mode once the block has drained
  task automatic write_legacy(input logic v);
    items_if.valid <= 1'b0;
    while (pending_cursor_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_if.valid       <= 1'b1;
    cfg_if.legacy_mode <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    legacy_q = v;
  endtask

  function automatic logic [WORD_W-1:0] row_pattern();
    logic [WORD_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = 16'h0000;
      1: v = 16'hffff;
      2: v = 16'haaaa;
      3: v = 16'h5555;
      default: v = WORD_W'($urandom);
    endcase
    return v;
  endfunction

  // Send a whole resource, a truncated one, or a few words of noise
  task automatic send_resource();
    logic [WORD_W-1:0] words [RESOURCE_WORDS];
    logic              first_start;
    int                shape;
    int                count;
    int                k;
    shape = $urandom_range(0, 9);
    words[0] = WORD_W'($urandom);
    words[1] = WORD_W'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      words[1][7:0] = 8'h00;
    end
    for (k = 2; k < RESOURCE_WORDS; k++) begin
      words[k] = row_pattern();
    end
    // at position 0 the flag is optional: the stream end already resyncs
    first_start = (position_q == 6'd0) ? 1'($urandom_range(0, 1)) : 1'b1;
    if (shape == 9) begin
      count = $urandom_range(1, 8);
      for (k = 0; k < count; k++) begin
        push_word(WORD_W'($urandom), ($urandom_range(0, 3) == 0), 1'b0, '0);
      end
    end else begin
      count = (shape <= 6) ? RESOURCE_WORDS : $urandom_range(1, RESOURCE_WORDS - 1);
      for (k = 0; k < count; k++) begin
        push_word(words[k], (k == 0) ? first_start : 1'b0, 1'b0, '0);
      end
    end
  endtask

  // Result side stalls on a pattern whose mode is drawn at random
  initial begin
    int unsigned tick;
    int unsigned mode;
    tick = 0;
    mode = 0;
    results_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 48 == 0) begin
        mode = $urandom_range(0, 3);
      end
      case (mode)
        0: results_if.ready <= 1'b1;
        1: results_if.ready <= (tick % 4 != 3);
        2: results_if.ready <= 1'($urandom_range(0, 1));
        default: results_if.ready <= (tick % 16 < 5);
      endcase
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each result beat with the oldest pending one
  always @(posedge clk) begin
    cursor_result_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_cursor_results.size() == 0) begin
        $error("result beat with nothing pending: kind %0d", results_if.kind);
        mismatch_count++;
      end else begin
        want = pending_cursor_results.pop_front();
        check_field("kind", 64'(want.kind), 64'(results_if.kind));
        check_field("hot_x", 64'(want.hot_x), 64'(results_if.hot_x));
        check_field("hot_y", 64'(want.hot_y), 64'(results_if.hot_y));
        check_field("picture_row", 64'(want.picture_row), 64'(results_if.picture_row));
        check_field("pixels", want.pixels, results_if.pixels);
        check_field("last", 64'(want.last), 64'(results_if.last));
      end
    end
  end

  initial begin
    cursor_result_t typed_r;
    int             n;
    int             resources;
    rst = 1'b1;
    items_if.valid     = 1'b0;
    items_if.word      = '0;
    items_if.start_req = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.legacy_mode = 1'b0;
    legacy_q   = 1'b1;
    position_q = '0;
    hot_x_q    = '0;
    resources  = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // walk the directed table
    for (n = 0; n < PLAN_LEN; n++) begin
      if (PLAN[n].op == STEP_CFG) begin
        write_legacy(PLAN[n].word[0]);
      end else begin
        typed_r = '0;
        typed_r.kind  = KIND_HOT;
        typed_r.hot_x = PLAN[n].hx;
        typed_r.hot_y = PLAN[n].hy;
        push_word(PLAN[n].word, PLAN[n].start, PLAN[n].typed, typed_r);
      end
    end

    // random resources, toggling legacy_mode between groups
    while (words_sent < PLAN_LEN + RANDOM_WORDS) begin
      if (resources % 6 == 5) begin
        write_legacy(~legacy_q);
      end
      send_resource();
      resources++;
    end

    items_if.valid <= 1'b0;
    while (pending_cursor_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
sv/cmd_pkg.sv
sv/cmd_item_if.sv
sv/cmd_result_if.sv
sv/cmd_cfg_if.sv
sv/cmd_row_pack.sv
sv/cursor_mask_decoder_top.sv
test/tb_cursor_mask_decoder_top.sv
